FILE: src/sjpc_pkg.sv
// Package for the stepper jog position controller.
// Holds the transaction, state and configuration types, operation codes and reset constants.
// No dependencies.
package sjpc_pkg;

   localparam int unsigned MaxPosWidth   = 15;
   localparam int unsigned IntervalWidth = 8;
   localparam int unsigned MsWidth       = 9;
   localparam int unsigned PosWidth      = 16;
   localparam int unsigned HomeWidth     = 15;

   localparam logic [MaxPosWidth-1:0]   MAX_POSITION_RESET = 15'd5900;
   localparam logic [IntervalWidth-1:0] SAMPLE_INTERVAL_RESET = 8'd50;
   localparam logic [MsWidth-1:0]       MS_MAX = 9'd511;
   localparam logic [HomeWidth-1:0]     HOME_MAX = 15'h7FFF;
   localparam logic signed [PosWidth-1:0] POS_MAX = 16'sh7FFF;
   localparam logic signed [PosWidth-1:0] POS_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      OP_STEP = 2'd0,
      OP_JOG  = 2'd1,
      OP_HOME = 2'd2,
      OP_TICK = 2'd3
   } op_type;

   typedef enum logic {
      CSR_MAX_POSITION       = 1'b0,
      CSR_SAMPLE_INTERVAL_MS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]        op;
      logic signed [7:0] jog_steps;
      logic              endstop_level;
   } req_item_type;

   typedef struct packed {
      logic                       step_pulse;
      logic                       step_up;
      logic                       coils_off;
      logic signed [PosWidth-1:0] position;
      logic                       endstop_hit;
      logic                       homing_active;
   } rsp_item_type;

   typedef struct packed {
      logic signed [PosWidth-1:0] pending_steps;
      logic signed [PosWidth-1:0] abs_position;
      logic                       endstop_sampled;
      logic [MsWidth-1:0]         ms_since_sample;
      logic                       homing_mode;
      logic [HomeWidth-1:0]       home_count;
   } state_type;

   typedef struct packed {
      logic [MaxPosWidth-1:0]   max_position;
      logic [IntervalWidth-1:0] sample_interval_ms;
   } cfg_type;

endpackage

FILE: src/sjpc_step_logic.sv
// Next-state and result logic for one transaction of the stepper jog position controller.
// Purely combinational; depends on sjpc_pkg.
module sjpc_step_logic (
   input  sjpc_pkg::req_item_type item,
   input  sjpc_pkg::state_type    cur,
   input  sjpc_pkg::cfg_type      cfg,
   output sjpc_pkg::state_type    nxt,
   output sjpc_pkg::rsp_item_type result
);
   import sjpc_pkg::*;

   logic signed [PosWidth:0]   jog_sum;
   logic signed [PosWidth-1:0] pend;
   logic                       done;
   logic                       pulse;
   logic                       up;
   logic                       off;

   always_comb begin
      nxt     = cur;
      done    = 1'b0;
      pulse   = 1'b0;
      up      = 1'b0;
      off     = 1'b0;
      pend    = cur.pending_steps;
      jog_sum = {cur.pending_steps[PosWidth-1], cur.pending_steps}
              + {{(PosWidth-7){item.jog_steps[7]}}, item.jog_steps};
      case (op_type'(item.op))
         OP_TICK: begin
            if (cur.ms_since_sample != MS_MAX) begin
               nxt.ms_since_sample = cur.ms_since_sample + 1'b1;
            end
         end
         OP_JOG: begin
            if (!cur.homing_mode) begin
               if (jog_sum[PosWidth] != jog_sum[PosWidth-1]) begin
                  nxt.pending_steps = jog_sum[PosWidth] ? POS_MIN : POS_MAX;
               end else begin
                  nxt.pending_steps = jog_sum[PosWidth-1:0];
               end
            end
         end
         OP_HOME: begin
            nxt.homing_mode   = 1'b1;
            nxt.home_count    = '0;
            nxt.pending_steps = '0;
         end
         default: begin
            if (cur.ms_since_sample > {1'b0, cfg.sample_interval_ms}) begin
               nxt.endstop_sampled = !item.endstop_level;
               nxt.ms_since_sample = '0;
            end
            if (cur.homing_mode) begin
               if (!nxt.endstop_sampled) begin
                  pulse = 1'b1;
                  done  = 1'b1;
                  if (cur.home_count != HOME_MAX) begin
                     nxt.home_count = cur.home_count + 1'b1;
                  end
               end else begin
                  nxt.homing_mode  = 1'b0;
                  pend             = $signed({1'b0, cur.home_count});
                  nxt.home_count   = '0;
                  nxt.abs_position = '0;
               end
            end
            if (!done) begin
               if (nxt.endstop_sampled && pend < 0) begin
                  pend = '0;
               end
               if (nxt.abs_position >= $signed({1'b0, cfg.max_position}) && pend > 0) begin
                  pend = '0;
               end
               if (pend != 0) begin
                  pulse = 1'b1;
                  if (pend > 0) begin
                     up   = 1'b1;
                     pend = pend - 16'sd1;
                     if (nxt.abs_position != POS_MAX) begin
                        nxt.abs_position = nxt.abs_position + 16'sd1;
                     end
                  end else begin
                     pend = pend + 16'sd1;
                     if (nxt.abs_position != POS_MIN) begin
                        nxt.abs_position = nxt.abs_position - 16'sd1;
                     end
                  end
               end else begin
                  off = 1'b1;
               end
               nxt.pending_steps = pend;
            end
         end
      endcase
      result.step_pulse    = pulse;
      result.step_up       = up;
      result.coils_off     = off;
      result.position      = nxt.abs_position;
      result.endstop_hit   = nxt.endstop_sampled;
      result.homing_active = nxt.homing_mode;
   end

endmodule

FILE: src/stepper_jog_position_controller_top.sv
// Top level of the stepper jog position controller.
// Input register, state and configuration registers, result register; uses sjpc_pkg and
// sjpc_step_logic.
//
// One transaction per cycle, back to back, unless rsp_stall backs up the result register: a
// request is registered, worked out by a single pass of next-state logic against the controller
// state and written to the result register once that register can take it. The
// result register is refilled as it drains; req_stall rises only when both registers are full
// and rsp_stall is high. Configuration writes are always taken (csr_ready is high) and belong
// to idle periods. After reset the controller is homing and max_position is 5900, the endstop
// sample interval 50 ms.
module stepper_jog_position_controller_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sjpc_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sjpc_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [14:0]            csr_data
);
   import sjpc_pkg::*;

   req_item_type in_item_ff;
   logic         in_valid_ff;
   logic         in_valid_in;
   rsp_item_type out_item_ff;
   logic         out_valid_ff;
   state_type    state_ff;
   state_type    state_in;
   cfg_type      cfg_ff;
   rsp_item_type result;
   logic         advance;
   logic         accept;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   sjpc_step_logic u_step (
      .item   (in_item_ff),
      .cur    (state_ff),
      .cfg    (cfg_ff),
      .nxt    (state_in),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{pending_steps: '0, abs_position: '0, endstop_sampled: 1'b0,
                           ms_since_sample: '0, homing_mode: 1'b1, home_count: '0};
         cfg_ff       <= '{max_position: MAX_POSITION_RESET,
                           sample_interval_ms: SAMPLE_INTERVAL_RESET};
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_MAX_POSITION:       cfg_ff.max_position       <= csr_data;
               CSR_SAMPLE_INTERVAL_MS: cfg_ff.sample_interval_ms <= csr_data[IntervalWidth-1:0];
               default:                cfg_ff                    <= cfg_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

endmodule

FILE: src/sjpc_checker.sv
// Port-level checker for the stepper jog position controller, bound to the top level.
// Depends on sjpc_pkg and stepper_jog_position_controller_top.
module sjpc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input sjpc_pkg::rsp_item_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   a_pulse_or_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.step_pulse && rsp_item.coils_off))
      else $error("step issued with coils off");

   a_up_needs_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.step_up |-> rsp_item.step_pulse)
      else $error("direction up without a step");

   a_homing_down: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.homing_active |-> !rsp_item.step_up)
      else $error("upward step while homing");

endmodule

bind stepper_jog_position_controller_top sjpc_checker u_sjpc_checker (.*);

FILE: sim/tb.sv
// Self-checking bench for stepper_jog_position_controller_top.
// Queue-fed driver and clocked monitor with its own controller predictor;
// depends on sjpc_pkg and the top level only.
`timescale 1ns / 100ps

module tb;
   import sjpc_pkg::*;

   localparam int CYCLE_LIMIT      = 8_000_000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int LONG_HOLD_AFTER  = 150;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [14:0]  csr_data = '0;

   stepper_jog_position_controller_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // controller mirror
   logic signed [PosWidth-1:0] ctl_pending;
   logic signed [PosWidth-1:0] ctl_position;
   logic                       ctl_endstop;
   logic [MsWidth-1:0]         ctl_ms;
   logic                       ctl_homing;
   logic [HomeWidth-1:0]       ctl_home_count;
   logic [MaxPosWidth-1:0]     lim_max_position;
   logic [IntervalWidth-1:0]   lim_interval;

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];

   int  cycle_count = 0;
   int  n_accepted = 0;
   int  n_results = 0;
   int  n_steps = 0;
   int  n_csr_writes = 0;
   int  homes_finished = 0;
   int  pos_low = 0;
   int  pos_high = 0;
   int  mismatch_count = 0;
   int  send_gap = 0;
   int  send_rate = 1;
   int  stall_left = 0;
   int  stall_rate = 1;
   bit  no_idle = 1'b0;
   bit  long_hold = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic signed [PosWidth-1:0] saturate16(int v);
      if (v > int'(POS_MAX)) return POS_MAX;
      if (v < int'(POS_MIN)) return POS_MIN;
      return v[PosWidth-1:0];
   endfunction

   function automatic rsp_item_type advance_controller(req_item_type r);
      rsp_item_type o;
      logic         homing_step;
      o = '0;
      homing_step = 1'b0;
      case (op_type'(r.op))
         OP_TICK: begin
            if (ctl_ms != MS_MAX) ctl_ms = ctl_ms + 1'b1;
         end
         OP_JOG: begin
            if (!ctl_homing) ctl_pending = saturate16(int'(ctl_pending) + int'(r.jog_steps));
         end
         OP_HOME: begin
            ctl_homing     = 1'b1;
            ctl_home_count = '0;
            ctl_pending    = '0;
         end
         OP_STEP: begin
            if (ctl_ms > lim_interval) begin
               ctl_endstop = ~r.endstop_level;
               ctl_ms      = '0;
            end
            if (ctl_homing) begin
               if (!ctl_endstop) begin
                  o.step_pulse = 1'b1;
                  if (ctl_home_count != HOME_MAX) ctl_home_count = ctl_home_count + 1'b1;
                  homing_step = 1'b1;
               end else begin
                  ctl_homing     = 1'b0;
                  ctl_pending    = $signed({1'b0, ctl_home_count});
                  ctl_home_count = '0;
                  ctl_position   = '0;
                  homes_finished++;
               end
            end
            if (!homing_step) begin
               if (ctl_endstop && ctl_pending < 0) ctl_pending = '0;
               if (int'(ctl_position) >= int'(lim_max_position) && ctl_pending > 0)
                  ctl_pending = '0;
               if (ctl_pending > 0) begin
                  o.step_pulse = 1'b1;
                  o.step_up    = 1'b1;
                  ctl_pending  = ctl_pending - 16'sd1;
                  ctl_position = saturate16(int'(ctl_position) + 1);
               end else if (ctl_pending < 0) begin
                  o.step_pulse = 1'b1;
                  ctl_pending  = ctl_pending + 16'sd1;
                  ctl_position = saturate16(int'(ctl_position) - 1);
               end else begin
                  o.coils_off = 1'b1;
               end
            end
         end
         default: ;
      endcase
      o.position      = ctl_position;
      o.endstop_hit   = ctl_endstop;
      o.homing_active = ctl_homing;
      if (int'(ctl_position) < pos_low) pos_low = int'(ctl_position);
      if (int'(ctl_position) > pos_high) pos_high = int'(ctl_position);
      return o;
   endfunction

   always @(posedge clock) begin : driver
      if (!reset && (!req_valid || !req_stall)) begin
         if ($urandom_range(0, 63) == 0) send_rate = $urandom_range(0, 3);
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 15) < send_rate) begin
            send_gap = $urandom_range(0, 14);
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_item  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (!reset) begin
         if ($urandom_range(0, 63) == 0) stall_rate = $urandom_range(0, 3);
         if (stall_left > 0) stall_left--;
         else if (!no_idle && $urandom_range(0, 15) < stall_rate)
            stall_left = $urandom_range(1, 15);
         rsp_stall <= long_hold || stall_left != 0;
      end
   end

   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (reset) begin
         ctl_pending      = '0;
         ctl_position     = '0;
         ctl_endstop      = 1'b0;
         ctl_ms           = '0;
         ctl_homing       = 1'b1;
         ctl_home_count   = '0;
         lim_max_position = MAX_POSITION_RESET;
         lim_interval     = SAMPLE_INTERVAL_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            n_csr_writes++;
            case (csr_index_type'(csr_index))
               CSR_MAX_POSITION:       lim_max_position = csr_data;
               CSR_SAMPLE_INTERVAL_MS: lim_interval     = csr_data[IntervalWidth-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(advance_controller(req_item));
            n_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (expected_rsps.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: result %0d arrived with nothing expected", $time, n_results);
               mismatch_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (want.step_pulse) n_steps++;
               if (rsp_item.step_pulse !== want.step_pulse || rsp_item.step_up !== want.step_up
                   || rsp_item.coils_off !== want.coils_off
                   || rsp_item.position !== want.position
                   || rsp_item.endstop_hit !== want.endstop_hit
                   || rsp_item.homing_active !== want.homing_active) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: result %0d mismatch", $time, n_results);
                     $display("   expected pulse %b up %b off %b pos %0d hit %b homing %b",
                              want.step_pulse, want.step_up, want.coils_off, want.position,
                              want.endstop_hit, want.homing_active);
                     $display("   actual   pulse %b up %b off %b pos %0d hit %b homing %b",
                              rsp_item.step_pulse, rsp_item.step_up, rsp_item.coils_off,
                              rsp_item.position, rsp_item.endstop_hit, rsp_item.homing_active);
                  end
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // hold the result side off long enough to back the block up
   initial begin : long_backpressure
      wait (n_accepted >= LONG_HOLD_AFTER);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   task automatic queue_req(op_type op, int jog, logic level);
      req_item_type r;
      r.op            = op;
      r.jog_steps     = jog[7:0];
      r.endstop_level = level;
      pending_reqs.push_back(r);
   endtask

   function automatic int pick_jog();
      case ($urandom_range(0, 7))
         0:       return -100;
         1:       return 100;
         default: return int'($urandom_range(0, 200)) - 100;
      endcase
   endfunction

   function automatic logic rand_level();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic write_register(csr_index_type idx, logic [14:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_until_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_random_traffic(int n, int interval);
      int made;
      int kind;
      int k;
      made = 0;
      while (made < n) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            k = $urandom_range(1, 3);
            repeat (k) queue_req(OP_JOG, pick_jog(), rand_level());
            made += k;
            k = $urandom_range(1, 30);
            repeat (k) begin
               if ($urandom_range(0, 5) == 0) begin
                  queue_req(OP_TICK, pick_jog(), rand_level());
                  made++;
               end
               queue_req(OP_STEP, pick_jog(), rand_level());
               made++;
            end
         end else if (kind < 70) begin
            k = interval + $urandom_range(0, 2);
            repeat (k) queue_req(OP_TICK, pick_jog(), rand_level());
            queue_req(OP_STEP, pick_jog(), kind < 58 ? 1'b1 : rand_level());
            made += k + 1;
         end else if (kind < 85) begin
            queue_req(OP_HOME, pick_jog(), rand_level());
            k = $urandom_range(0, 20);
            repeat (k) queue_req(OP_STEP, pick_jog(), rand_level());
            repeat (interval + 1) queue_req(OP_TICK, pick_jog(), rand_level());
            queue_req(OP_STEP, pick_jog(), 1'b0);
            made += k + interval + 3;
         end else begin
            k = $urandom_range(1, 8);
            repeat (k)
               queue_req(op_type'($urandom_range(0, 3)), pick_jog(), rand_level());
            made += k;
         end
      end
   endtask

   initial begin : stimulus
      int interval;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings
      queue_random_traffic(100, int'(SAMPLE_INTERVAL_RESET));
      wait_until_idle();

      write_register(CSR_MAX_POSITION, 15'd3);
      write_register(CSR_SAMPLE_INTERVAL_MS, 15'd0);
      queue_req(OP_HOME, 0, 1'b1);
      queue_req(OP_JOG, 100, 1'b0);
      queue_req(OP_STEP, -100, 1'b0);
      queue_req(OP_STEP, 0, 1'b0);
      queue_req(OP_TICK, 100, 1'b0);
      queue_req(OP_STEP, 0, 1'b0);
      queue_req(OP_STEP, 0, 1'b1);
      queue_req(OP_STEP, 0, 1'b0);
      queue_req(OP_JOG, 100, 1'b1);
      queue_req(OP_STEP, 0, 1'b0);
      queue_req(OP_STEP, 0, 1'b1);
      queue_req(OP_JOG, -100, 1'b0);
      queue_req(OP_STEP, 0, 1'b1);
      queue_req(OP_TICK, -100, 1'b0);
      queue_req(OP_STEP, 0, 1'b1);
      queue_req(OP_JOG, -100, 1'b1);
      queue_req(OP_JOG, -1, 1'b0);
      queue_req(OP_STEP, 0, 1'b1);
      queue_req(OP_HOME, 100, 1'b0);
      queue_req(OP_JOG, 5, 1'b1);
      queue_req(OP_STEP, 0, 1'b0);
      queue_req(OP_TICK, 0, 1'b1);
      queue_req(OP_STEP, 0, 1'b1);
      queue_req(OP_TICK, 0, 1'b0);
      queue_req(OP_STEP, 0, 1'b0);
      queue_random_traffic(120, 0);
      wait_until_idle();

      interval = $urandom_range(0, 20);
      write_register(CSR_MAX_POSITION, 15'($urandom_range(0, 3) == 0 ?
                     $urandom_range(0, 32767) : $urandom_range(0, 200)));
      write_register(CSR_SAMPLE_INTERVAL_MS, 15'(interval));
      queue_random_traffic(150, interval);
      wait_until_idle();

      // closing stretch runs without idling
      write_register(CSR_MAX_POSITION, 15'd40);
      write_register(CSR_SAMPLE_INTERVAL_MS, 15'd2);
      no_idle = 1'b1;
      queue_random_traffic(150, 2);
      wait_until_idle();

      $display("Checked %0d results from %0d transactions: %0d steps, %0d homing searches done.",
               n_results, n_accepted, n_steps, homes_finished);
      $display("Position spanned %0d to %0d over %0d register writes and %0d cycles.",
               pos_low, pos_high, n_csr_writes, cycle_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/sjpc_pkg.sv
src/sjpc_step_logic.sv
src/stepper_jog_position_controller_top.sv
src/sjpc_checker.sv
sim/tb.sv
